// ===== hw/rtl/common_log_format_lexer_unit_assert.svh =====
// Assertion macros of the log lexer, used by the result register bank.
`ifndef COMMON_LOG_FORMAT_LEXER_UNIT_ASSERT_SVH
`define COMMON_LOG_FORMAT_LEXER_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CLF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define CLF_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/clf_pkg.sv =====
// Shared types, constants and helper functions of the log lexer.
package clf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_RES = 8;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int NUM_FIELDS = 15;
    localparam int MONTHS = 12;

    typedef enum logic [2:0] {
        EV_SBYTE = 3'd0,
        EV_SEND  = 3'd1,
        EV_INT   = 3'd2,
        EV_DEFP  = 3'd3,
        EV_DONE  = 3'd4,
        EV_DROP  = 3'd5
    } ev_t;

    // Order matters: the parser compares classes by magnitude.
    typedef enum logic [3:0] {
        C_WS  = 4'd0,
        C_EOL = 4'd1,
        C_TOK = 4'd2,
        C_DIG = 4'd3,
        C_QUO = 4'd4,
        C_LBR = 4'd5,
        C_RBR = 4'd6,
        C_SLA = 4'd7,
        C_COL = 4'd8,
        C_MIN = 4'd9,
        C_PLU = 4'd10
    } cls_t;

    typedef struct packed {
        ev_t         ev;
        logic [3:0]  slot;
        logic [7:0]  text;
        logic [31:0] num;
        logic [31:0] off;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]  cnt;
    } burst_t;

    localparam logic [31:0] MONTH_KEYS [MONTHS] = '{
        32'h006a616e, 32'h00666562, 32'h006d6172, 32'h00617072,
        32'h006d6179, 32'h006a756e, 32'h006a756c, 32'h00617567,
        32'h00736570, 32'h006f6374, 32'h006e6f76, 32'h00646563
    };

    function automatic cls_t byte_class(logic [7:0] c);
        cls_t k;
        if (c == 8'h0a || c == 8'h0d) begin
            k = C_EOL;
        end else if (c <= 8'h20) begin
            k = C_WS;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = C_DIG;
        end else begin
            case (c)
                8'h22:   k = C_QUO;
                8'h5b:   k = C_LBR;
                8'h5d:   k = C_RBR;
                8'h2f:   k = C_SLA;
                8'h3a:   k = C_COL;
                8'h2d:   k = C_MIN;
                8'h2b:   k = C_PLU;
                default: k = C_TOK;
            endcase
        end
        return k;
    endfunction

    // Appends one result to a burst; results beyond the capacity are lost.
    function automatic burst_t push(burst_t b, ev_t ev, logic [4:0] fc, logic [7:0] t,
                                    logic [31:0] num, logic [31:0] off);
        burst_t r;
        r = b;
        if (b.cnt < RES_CNT_W'(MAX_RES)) begin
            r.res[b.cnt[RES_IDX_W-1:0]] = '{ev: ev, slot: fc[3:0], text: t, num: num, off: off};
            r.cnt = b.cnt + RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [4:0] bump(logic [4:0] fc);
        return (fc < 5'd31) ? fc + 5'd1 : fc;
    endfunction

endpackage

// ===== hw/rtl/clf_parser.sv =====
// Parser state machine: classes one byte and builds the burst of results it causes.
module clf_parser #(
    parameter int VALUE_WIDTH = clf_pkg::VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              in_kind,
    input  logic [7:0]        in_byte,
    input  logic              cfg_wr,
    input  logic [31:0]       cfg_data,
    output clf_pkg::burst_t   burst
);

    localparam int VW = VALUE_WIDTH;
    localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    typedef enum logic [5:0] {
        S_LINE, S_HOST, S_GAP1, S_IDENT, S_GAP2, S_USER, S_GAP3, S_GAP4,
        S_PROTO, S_PROTO_Q, S_GAP5, S_STATUS, S_GAP6, S_BYTES, S_SKIP, S_DAY0,
        S_DAY, S_MON0, S_MONN, S_YEAR0, S_YEAR, S_MONT, S_HOUR0, S_HOUR,
        S_MIN0, S_MIN, S_SEC0, S_SEC, S_ZONE0, S_ZONE, S_ZONE_END, S_METHOD,
        S_GAP7, S_PATH, S_PATH_Q, S_GAP8
    } state_t;

    state_t          st_reg, st_next;
    logic [4:0]      fc_reg, fc_next;
    logic [VW-1:0]   num_reg, num_next;
    logic [VW-1:0]   day_reg, day_next;
    logic [MW-1:0]   mon_reg, mon_next;
    logic [VW-1:0]   year_reg, year_next;
    logic [VW-1:0]   hour_reg, hour_next;
    logic [VW-1:0]   minute_reg, minute_next;
    logic [VW-1:0]   sec_reg, sec_next;
    logic [VW-1:0]   zone_reg, zone_next;
    logic            zneg_reg, zneg_next;
    logic [31:0]     off_reg, off_next;

    function automatic logic [VW-1:0] acc10(logic [VW-1:0] a, logic [7:0] c);
        return (a << 3) + (a << 1) + VW'(c[3:0]);
    endfunction

    function automatic logic [31:0] to32(logic [MW-1:0] v);
        return v[31:0];
    endfunction

    always_comb begin
        clf_pkg::burst_t b;
        clf_pkg::cls_t   k;
        logic [4:0]      fc;
        logic [31:0]     m32;
        logic            found;
        logic [3:0]      midx;
        logic [VW-1:0]   zfin;

        b = '0;
        fc = fc_reg;
        st_next = st_reg;
        num_next = num_reg;
        day_next = day_reg;
        mon_next = mon_reg;
        year_next = year_reg;
        hour_next = hour_reg;
        minute_next = minute_reg;
        sec_next = sec_reg;
        zone_next = zone_reg;
        zneg_next = zneg_reg;
        off_next = off_reg;
        k = clf_pkg::byte_class(in_byte);
        m32 = {mon_reg[23:0], in_byte | 8'h20};
        found = 1'b0;
        midx = 4'd0;
        for (int i = 0; i < clf_pkg::MONTHS; i++) begin
            if (!found && mon_reg[31:0] == clf_pkg::MONTH_KEYS[i]) begin
                found = 1'b1;
                midx = 4'(i + 1);
            end
        end
        zfin = zneg_reg ? (VW'(0) - zone_reg) : zone_reg;

        if (in_kind) begin
            // End of input closes an open string and reports the pending line.
            if (st_reg == S_HOST || st_reg == S_IDENT || st_reg == S_USER ||
                st_reg == S_PROTO || st_reg == S_PROTO_Q || st_reg == S_METHOD ||
                st_reg == S_PATH || st_reg == S_PATH_Q) begin
                b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                fc = clf_pkg::bump(fc);
            end
            if (fc != 5'd0) begin
                b = clf_pkg::push(b, (fc == 5'(clf_pkg::NUM_FIELDS)) ? clf_pkg::EV_DONE :
                                  clf_pkg::EV_DROP, fc, 8'd0, 32'd0, off_reg);
            end
            fc = 5'd0;
            st_next = S_LINE;
        end else begin
            off_next = off_reg + 32'd1;
            case (st_reg)
                S_LINE: begin
                    if (fc != 5'd0) begin
                        b = clf_pkg::push(b, (fc == 5'(clf_pkg::NUM_FIELDS)) ?
                                          clf_pkg::EV_DONE : clf_pkg::EV_DROP,
                                          fc, 8'd0, 32'd0, off_next);
                        fc = 5'd0;
                    end
                    if (k > clf_pkg::C_EOL) begin
                        if (k == clf_pkg::C_MIN) begin
                            b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                            fc = clf_pkg::bump(fc);
                            st_next = S_GAP1;
                        end else begin
                            b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                            st_next = S_HOST;
                        end
                    end
                end
                S_HOST, S_IDENT, S_USER: begin
                    if (k > clf_pkg::C_EOL) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        if (k == clf_pkg::C_WS) begin
                            st_next = (st_reg == S_HOST) ? S_GAP1 :
                                      (st_reg == S_IDENT) ? S_GAP2 : S_GAP3;
                        end else begin
                            st_next = S_LINE;
                        end
                    end
                end
                S_GAP1, S_GAP2: begin
                    if (k > clf_pkg::C_EOL) begin
                        if (k == clf_pkg::C_MIN) begin
                            b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                            fc = clf_pkg::bump(fc);
                            st_next = (st_reg == S_GAP1) ? S_GAP2 : S_GAP3;
                        end else begin
                            b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                            st_next = (st_reg == S_GAP1) ? S_IDENT : S_USER;
                        end
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end
                end
                S_GAP3, S_GAP4: begin
                    if (st_reg == S_GAP3 && k == clf_pkg::C_LBR) begin
                        st_next = S_DAY0;
                    end else if (st_reg == S_GAP4 && k == clf_pkg::C_QUO) begin
                        st_next = S_METHOD;
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end else if (k == clf_pkg::C_MIN) begin
                        // A hyphen is reported as three zero-valued fields, whichever field group it stands for.
                        for (int i = 0; i < 3; i++) begin
                            b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                            fc = clf_pkg::bump(fc);
                        end
                        st_next = (st_reg == S_GAP3) ? S_GAP4 : S_GAP5;
                    end
                end
                S_PROTO: begin
                    if (k == clf_pkg::C_QUO) begin
                        st_next = S_PROTO_Q;
                    end else if (k == clf_pkg::C_EOL) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = S_LINE;
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                    end
                end
                S_PROTO_Q: begin
                    if (k > clf_pkg::C_EOL) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, 8'h22, 32'd0, 32'd0);
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                        st_next = S_PROTO;
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_GAP5;
                    end
                end
                S_GAP5, S_GAP6: begin
                    if (k == clf_pkg::C_DIG) begin
                        num_next = VW'(in_byte[3:0]);
                        st_next = (st_reg == S_GAP5) ? S_STATUS : S_BYTES;
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end else if (k == clf_pkg::C_MIN) begin
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = (st_reg == S_GAP5) ? S_GAP6 : S_SKIP;
                    end
                end
                S_STATUS: begin
                    if (k == clf_pkg::C_DIG) begin
                        num_next = acc10(num_reg, in_byte);
                    end else if (k == clf_pkg::C_WS) begin
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(num_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = S_GAP6;
                    end else begin
                        st_next = S_LINE;
                    end
                end
                S_BYTES: begin
                    if (k == clf_pkg::C_DIG) begin
                        num_next = acc10(num_reg, in_byte);
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(num_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (k == clf_pkg::C_EOL) st_next = S_LINE;
                end
                S_DAY0, S_YEAR0, S_HOUR0, S_MIN0, S_SEC0: begin
                    if (k == clf_pkg::C_DIG) begin
                        case (st_reg)
                            S_DAY0: begin
                                day_next = VW'(in_byte[3:0]);
                                st_next = S_DAY;
                            end
                            S_YEAR0: begin
                                year_next = VW'(in_byte[3:0]);
                                st_next = S_YEAR;
                            end
                            S_HOUR0: begin
                                hour_next = VW'(in_byte[3:0]);
                                st_next = S_HOUR;
                            end
                            S_MIN0: begin
                                minute_next = VW'(in_byte[3:0]);
                                st_next = S_MIN;
                            end
                            default: begin
                                sec_next = VW'(in_byte[3:0]);
                                st_next = S_SEC;
                            end
                        endcase
                    end else begin
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                    end
                end
                S_DAY: begin
                    if (k == clf_pkg::C_DIG) day_next = acc10(day_reg, in_byte);
                    else if (k == clf_pkg::C_SLA) st_next = S_MON0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_MON0: begin
                    if (k == clf_pkg::C_DIG) begin
                        mon_next = MW'(in_byte[3:0]);
                        st_next = S_MONN;
                    end else if (k == clf_pkg::C_TOK) begin
                        mon_next = MW'(in_byte | 8'h20);
                        st_next = S_MONT;
                    end else begin
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                    end
                end
                S_MONN: begin
                    if (k == clf_pkg::C_DIG) mon_next = MW'(acc10(VW'(mon_reg), in_byte));
                    else if (k == clf_pkg::C_SLA) st_next = S_YEAR0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_YEAR: begin
                    if (k == clf_pkg::C_DIG) year_next = acc10(year_reg, in_byte);
                    else if (k == clf_pkg::C_COL) st_next = S_HOUR0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_MONT: begin
                    // A textual month collects lower-cased letters until the slash.
                    if (k == clf_pkg::C_TOK) begin
                        mon_next = MW'(m32);
                    end else if (k == clf_pkg::C_SLA) begin
                        if (found) begin
                            mon_next = MW'(midx);
                            st_next = S_YEAR0;
                        end else begin
                            st_next = S_SKIP;
                        end
                    end
                end
                S_HOUR: begin
                    if (k == clf_pkg::C_DIG) hour_next = acc10(hour_reg, in_byte);
                    else if (k == clf_pkg::C_COL) st_next = S_MIN0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_MIN: begin
                    if (k == clf_pkg::C_DIG) minute_next = acc10(minute_reg, in_byte);
                    else if (k == clf_pkg::C_COL) st_next = S_SEC0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_SEC: begin
                    if (k == clf_pkg::C_DIG) sec_next = acc10(sec_reg, in_byte);
                    else if (k == clf_pkg::C_WS) st_next = S_ZONE0;
                    else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_SKIP;
                end
                S_ZONE0: begin
                    if (k >= clf_pkg::C_MIN) begin
                        zneg_next = (k != clf_pkg::C_PLU);
                        zone_next = '0;
                        st_next = S_ZONE;
                    end else if (k == clf_pkg::C_DIG) begin
                        zneg_next = 1'b0;
                        zone_next = VW'(in_byte[3:0]);
                        st_next = S_ZONE;
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end
                end
                S_ZONE: begin
                    if (k == clf_pkg::C_DIG) begin
                        zone_next = acc10(zone_reg, in_byte);
                    end else begin
                        // The whole timestamp is reported once the zone ends.
                        zone_next = zfin;
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(year_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(mon_reg), 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(day_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(hour_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(minute_reg)),
                                          32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(sec_reg)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, to32(MW'(zfin)), 32'd0);
                        fc = clf_pkg::bump(fc);
                        if (k == clf_pkg::C_RBR) st_next = S_GAP4;
                        else st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_ZONE_END;
                    end
                end
                S_ZONE_END: begin
                    if (k == clf_pkg::C_RBR) st_next = S_GAP4;
                    else if (k == clf_pkg::C_EOL) st_next = S_LINE;
                end
                S_METHOD: begin
                    if (k == clf_pkg::C_QUO) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        for (int i = 0; i < 2; i++) begin
                            b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                            fc = clf_pkg::bump(fc);
                        end
                        st_next = S_GAP5;
                    end else if (k >= clf_pkg::C_TOK) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_GAP7;
                    end
                end
                S_GAP7: begin
                    if (k == clf_pkg::C_QUO) begin
                        for (int i = 0; i < 2; i++) begin
                            b = clf_pkg::push(b, clf_pkg::EV_INT, fc, 8'd0, 32'd0, 32'd0);
                            fc = clf_pkg::bump(fc);
                        end
                        st_next = S_GAP5;
                    end else if (k >= clf_pkg::C_TOK) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                        st_next = S_PATH;
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end
                end
                S_PATH: begin
                    if (k == clf_pkg::C_QUO) begin
                        st_next = S_PATH_Q;
                    end else if (k == clf_pkg::C_EOL || k == clf_pkg::C_WS) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = (k == clf_pkg::C_EOL) ? S_LINE : S_GAP8;
                    end else begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                    end
                end
                S_PATH_Q: begin
                    if (k >= clf_pkg::C_TOK) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, 8'h22, 32'd0, 32'd0);
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                        st_next = S_PATH;
                    end else if (k == clf_pkg::C_EOL) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = S_LINE;
                    end else begin
                        // A closing quote right after the path means no protocol was given.
                        b = clf_pkg::push(b, clf_pkg::EV_SEND, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        b = clf_pkg::push(b, clf_pkg::EV_DEFP, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = S_GAP5;
                    end
                end
                S_GAP8: begin
                    if (k == clf_pkg::C_QUO) begin
                        b = clf_pkg::push(b, clf_pkg::EV_DEFP, fc, 8'd0, 32'd0, 32'd0);
                        fc = clf_pkg::bump(fc);
                        st_next = S_GAP5;
                    end else if (k >= clf_pkg::C_TOK) begin
                        b = clf_pkg::push(b, clf_pkg::EV_SBYTE, fc, in_byte, 32'd0, 32'd0);
                        st_next = S_PROTO;
                    end else if (k == clf_pkg::C_EOL) begin
                        st_next = S_LINE;
                    end
                end
                default: st_next = S_LINE;
            endcase
        end
        fc_next = fc;
        burst = b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_LINE;
            fc_reg     <= 5'd0;
            num_reg    <= '0;
            day_reg    <= '0;
            mon_reg    <= '0;
            year_reg   <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            sec_reg    <= '0;
            zone_reg   <= '0;
            zneg_reg   <= 1'b0;
            off_reg    <= 32'd0;
        end else if (cfg_wr) begin
            off_reg <= cfg_data;
        end else if (step) begin
            st_reg     <= st_next;
            fc_reg     <= fc_next;
            num_reg    <= num_next;
            day_reg    <= day_next;
            mon_reg    <= mon_next;
            year_reg   <= year_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            sec_reg    <= sec_next;
            zone_reg   <= zone_next;
            zneg_reg   <= zneg_next;
            off_reg    <= off_next;
        end
    end

endmodule

// ===== hw/rtl/clf_burst.sv =====
// Result register bank that holds one byte's burst and hands it out one transfer at a time.
`include "common_log_format_lexer_unit_assert.svh"

module clf_burst (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  clf_pkg::burst_t   burst,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output clf_pkg::result_t  m_res
);

    clf_pkg::result_t [clf_pkg::MAX_RES-1:0] res_reg;
    logic [clf_pkg::RES_CNT_W-1:0]           cnt_reg;
    logic [clf_pkg::RES_IDX_W-1:0]           rd_reg;
    logic                                    xfer;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == clf_pkg::RES_CNT_W'(1));
    assign m_res    = res_reg[rd_reg];
    assign xfer     = m_tvalid && m_tready;
    assign free     = (cnt_reg == '0) || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= burst.cnt;
            rd_reg  <= '0;
        end else if (xfer) begin
            cnt_reg <= cnt_reg - clf_pkg::RES_CNT_W'(1);
            rd_reg  <= rd_reg + clf_pkg::RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= burst.res;
        end
    end

    `CLF_ASSERT_ALWAYS(a_load_when_free, !load || free, "burst loaded over pending results")
    `CLF_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= clf_pkg::RES_CNT_W'(clf_pkg::MAX_RES),
        "burst count out of range")
    `CLF_ASSERT_NEXT(a_last_empties, xfer && m_tlast && !load, !m_tvalid,
        "results remain after the last transfer")

endmodule

// ===== hw/rtl/common_log_format_lexer_unit.sv =====
// Flow: a byte is held in the input register after its transfer; its results are then
// loaded into the single result register bank and leave at one transfer per cycle while
// m_tready is high. One byte per cycle is taken while each byte yields at most one result
// and m_tready is high; a byte with more results holds the next until its last is taken.
// Reset: synchronous active-low; clears the parser to line start, the fields and the
// offset counter, and empties the input and result registers.
module common_log_format_lexer_unit #(
    parameter int VALUE_WIDTH = clf_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [3:0] slot, [11:4] text_byte, [43:12] number,
                                   // [75:44] offset, [79:76] zero
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic             burst_free;
    logic             consume;
    clf_pkg::burst_t  burst;
    clf_pkg::result_t res;

    assign consume   = in_valid_reg && burst_free;
    assign s_tready  = !in_valid_reg || burst_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    clf_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (consume),
        .in_kind  (in_kind_reg),
        .in_byte  (in_byte_reg),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .burst    (burst)
    );

    clf_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume),
        .burst    (burst),
        .free     (burst_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_res    (res)
    );

    assign m_tuser = res.ev;
    assign m_tdata = {4'd0, res.off, res.num, res.text, res.slot};

endmodule
